// ----- rtl/core/gf8_pkg.sv -----
// ----------------------------------------------------------------------------
// gf8_pkg
// Shared types, constants and bit-level helpers for the GF(2^8) unit.
// ----------------------------------------------------------------------------
package gf8_pkg;

    localparam int ModW  = 9;
    localparam int ByteW = 8;
    localparam int CmdW  = 2;
    localparam int NibN  = 16;

    localparam logic [ModW-1:0]  ModReset  = 9'h11b;
    localparam logic [ModW-1:0]  AesPoly   = 9'h11b;
    localparam logic [ByteW-1:0] SboxAdd   = 8'h63;
    localparam logic [ByteW-1:0] InvSboxAdd = 8'h05;

    typedef enum logic [CmdW-1:0] {
        CMD_MUL      = 2'd0,
        CMD_INV      = 2'd1,
        CMD_SBOX     = 2'd2,
        CMD_INV_SBOX = 2'd3
    } t_cmd;

    localparam logic [ByteW-1:0] FwdRows [0:7] =
        '{8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C, 8'hF8};
    localparam logic [ByteW-1:0] InvRows [0:7] =
        '{8'hA4, 8'h49, 8'h92, 8'h25, 8'h4A, 8'h94, 8'h29, 8'h52};

    function automatic logic [ByteW-1:0] affine_fwd(input logic [ByteW-1:0] v);
        logic [ByteW-1:0] o;
        for (int r = 0; r < ByteW; r++) begin
            o[r] = ^(FwdRows[r] & v);
        end
        return o ^ SboxAdd;
    endfunction

    function automatic logic [ByteW-1:0] affine_inv(input logic [ByteW-1:0] v);
        logic [ByteW-1:0] o;
        for (int r = 0; r < ByteW; r++) begin
            o[r] = ^(InvRows[r] & v);
        end
        return o ^ InvSboxAdd;
    endfunction

    // one-hot mask of the leading coefficient, zero for a zero polynomial
    function automatic logic [ModW-1:0] lead_bit(input logic [ModW-1:0] m);
        logic [ModW-1:0] t;
        t = '0;
        for (int k = 0; k < ModW; k++) begin
            if (m[k]) begin
                t = '0;
                t[k] = 1'b1;
            end
        end
        return t;
    endfunction

    // one conditional subtract of the modulus
    function automatic logic [ByteW-1:0] red1(input logic [ModW-1:0] w,
                                             input logic [ModW-1:0] m,
                                             input logic [ModW-1:0] top);
        logic [ModW-1:0] x;
        x = (|(w & top)) ? (w ^ m) : w;
        return x[ByteW-1:0];
    endfunction

endpackage

// ----- rtl/core/gf2_8_mul_inv_sbox_unit_core.sv -----
// ----------------------------------------------------------------------------
// gf2_8_mul_inv_sbox_unit_core
// GF(2^8) multiply, inverse and AES S-box unit with programmable modulus.
// Throughput: one item per cycle; the five-stage pipeline stalls as a whole
// only while the output register holds a result that is not taken.
// The inverse comes from an 8x8 GF(2) system solved by a 16x16 nibble match.
// Reset clears all stage valids and loads the modulus with 0x11b.
// ----------------------------------------------------------------------------
module gf2_8_mul_inv_sbox_unit_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gf8_pkg::ModW-1:0]  i_cfg_wdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [15:0]               i_s_tdata,  // operand_a, operand_b
    input  logic [1:0]                i_s_tuser,  // command
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [7:0]                o_m_tdata,  // result
    output logic [0:0]                o_m_tuser   // no_inverse
);
    import gf8_pkg::*;

    logic [ModW-1:0]  r_modulus;
    logic [4:0]       r_vld;
    logic             adv;

    t_cmd             r_cmd1, r_cmd2, r_cmd3, r_cmd4;
    logic             r_az1, r_az2, r_az3, r_az4;
    logic [ByteW-1:0] r_b1, r_b2;
    logic [ModW-1:0]  r_m1, r_top1;
    logic [ByteW-1:0] r_c0;
    logic [ByteW-1:0] r_col [0:7];
    logic [ByteW-1:0] r_lt  [0:NibN-1];
    logic [ByteW-1:0] r_ht  [0:NibN-1];
    logic [ByteW-1:0] r_prod3, r_prod4;
    logic [NibN-1:0]  r_fnd;
    logic [3:0]       r_lo  [0:NibN-1];
    logic [ByteW-1:0] r_res;
    logic             r_noinv;

    t_cmd             n_cmd;
    logic [ModW-1:0]  n_m, n_top;
    logic [ByteW-1:0] n_a, n_c0;
    logic [ByteW-1:0] n_col [0:7];
    logic [ByteW-1:0] n_lt  [0:NibN-1];
    logic [ByteW-1:0] n_ht  [0:NibN-1];
    logic [ByteW-1:0] n_prod;
    logic [NibN-1:0]  n_fnd;
    logic [3:0]       n_lo  [0:NibN-1];
    logic [3:0]       sel;
    logic             any;
    logic [ByteW-1:0] inv, n_res;
    logic             n_noinv;

    assign adv        = !r_vld[4] || i_m_tready;
    assign o_s_tready = adv;
    assign o_m_tvalid = r_vld[4];
    assign o_m_tdata  = r_res;
    assign o_m_tuser  = r_noinv;

    // stage 1: operand select, residue of a
    always_comb begin
        n_cmd = t_cmd'(i_s_tuser);
        n_m   = n_cmd[1] ? AesPoly : r_modulus;
        n_top = lead_bit(n_m);
        n_a   = (n_cmd == CMD_INV_SBOX) ? affine_inv(i_s_tdata[7:0]) : i_s_tdata[7:0];
        n_c0  = '0;
        for (int k = ByteW - 1; k >= 0; k--) begin
            n_c0 = red1({n_c0, n_a[k]}, n_m, n_top);
        end
    end

    // stage 2: residues of a*x^k
    always_comb begin
        n_col[0] = r_c0;
        for (int k = 1; k < ByteW; k++) begin
            n_col[k] = red1({n_col[k-1], 1'b0}, r_m1, r_top1);
        end
    end

    // stage 3: nibble tables and product
    always_comb begin
        n_prod = '0;
        for (int k = 0; k < ByteW; k++) begin
            if (r_b2[k]) begin
                n_prod = n_prod ^ r_col[k];
            end
        end
        for (int j = 0; j < NibN; j++) begin
            n_lt[j] = '0;
            n_ht[j] = '0;
            for (int k = 0; k < 4; k++) begin
                if (j[k]) begin
                    n_lt[j] = n_lt[j] ^ r_col[k];
                    n_ht[j] = n_ht[j] ^ r_col[k+4];
                end
            end
        end
    end

    // stage 4: lowest matching low nibble for each high nibble
    always_comb begin
        for (int h = 0; h < NibN; h++) begin
            n_fnd[h] = 1'b0;
            n_lo[h]  = '0;
            for (int l = NibN - 1; l >= 0; l--) begin
                if (r_lt[l] == (r_ht[h] ^ 8'd1)) begin
                    n_fnd[h] = 1'b1;
                    n_lo[h]  = 4'(l);
                end
            end
        end
    end

    // stage 5: lowest high nibble, final map
    always_comb begin
        sel = '0;
        any = 1'b0;
        for (int h = NibN - 1; h >= 0; h--) begin
            if (r_fnd[h]) begin
                sel = 4'(h);
                any = 1'b1;
            end
        end
        n_noinv = !r_az4 && !any && (r_cmd4 != CMD_MUL);
        inv     = (r_az4 || !any) ? '0 : {sel, r_lo[sel]};
        unique case (r_cmd4)
            CMD_MUL:  n_res = r_prod4;
            CMD_INV:  n_res = inv;
            CMD_SBOX: n_res = affine_fwd(inv);
            default:  n_res = inv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= ModReset;
            r_vld     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (adv) begin
                r_vld <= {r_vld[3:0], i_s_tvalid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cmd1  <= n_cmd;
            r_az1   <= (n_a == '0);
            r_b1    <= i_s_tdata[15:8];
            r_m1    <= n_m;
            r_top1  <= n_top;
            r_c0    <= n_c0;
            r_cmd2  <= r_cmd1;
            r_az2   <= r_az1;
            r_b2    <= r_b1;
            r_col   <= n_col;
            r_cmd3  <= r_cmd2;
            r_az3   <= r_az2;
            r_prod3 <= n_prod;
            r_lt    <= n_lt;
            r_ht    <= n_ht;
            r_cmd4  <= r_cmd3;
            r_az4   <= r_az3;
            r_prod4 <= r_prod3;
            r_fnd   <= n_fnd;
            r_lo    <= n_lo;
            r_res   <= n_res;
            r_noinv <= n_noinv;
        end
    end

    a_rdy: assert property (@(posedge i_clk)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("stage valids not cleared by reset");

    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("no-inverse result is not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!adv && $past(i_rst_n)) |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved during stall");

endmodule

// ----- verif/tb_gf2_8_mul_inv_sbox_unit_core.sv -----
// ----------------------------------------------------------------------------
// tb_gf2_8_mul_inv_sbox_unit_core
// Self-checking bench for the GF(2^8) multiply, inverse and S-box unit. A
// directed table covers operand extremes, every command and the degenerate
// moduli; random traffic then runs under several modulus settings and
// idle/stall mixes. Each result transfer is matched against a behavioral
// predictor in order.
// ----------------------------------------------------------------------------
module tb_gf2_8_mul_inv_sbox_unit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import gf8_pkg::*;

    typedef struct packed {
        logic [7:0] res;
        logic       noinv;
    } t_gf_out;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] a;
        logic [7:0] b;
        logic       chk;
        logic [7:0] res;
        logic       noinv;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_wdata = '0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic [1:0] i_s_tuser = '0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;
    logic [0:0] o_m_tuser;

    gf2_8_mul_inv_sbox_unit_core u_top (.*);

    always #4 i_clk = ~i_clk;

    logic [8:0] modulus_q = 9'h11b;
    t_gf_out    pending_q[$];
    int         n_err = 0;
    int         n_out = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;

    function automatic logic [14:0] clmul(input logic [7:0] a, input logic [7:0] b);
        logic [14:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++)
            if (b[k]) acc ^= 15'(a) << k;
        return acc;
    endfunction

    function automatic logic [7:0] reduce(input logic [14:0] x, input logic [8:0] m);
        int deg;
        logic [23:0] w;
        deg = -1;
        w = 24'(x);
        for (int k = 0; k < 9; k++)
            if (m[k]) deg = k;
        if (deg < 0) return x[7:0];
        for (int k = 14; k >= deg; k--)
            if (w[k]) w ^= 24'(m) << (k - deg);
        return w[7:0];
    endfunction

    function automatic logic [8:0] invert(input logic [7:0] a, input logic [8:0] m);
        if (a == 0) return '0;
        for (int i = 0; i < 256; i++)
            if (reduce(clmul(a, 8'(i)), m) == 8'd1) return {1'b0, 8'(i)};
        return 9'h100;
    endfunction

    function automatic logic [7:0] affine(input logic [7:0] v, input logic fwd);
        logic [7:0] o;
        for (int r = 0; r < 8; r++)
            o[r] = ^((fwd ? FwdRows[r] : InvRows[r]) & v);
        return o ^ (fwd ? SboxAdd : InvSboxAdd);
    endfunction

    function automatic t_gf_out gf_predict(input t_cmd c, input logic [7:0] a,
                                           input logic [7:0] b);
        logic [8:0] iv;
        t_gf_out    o;
        case (c)
            CMD_MUL: begin
                o.res = reduce(clmul(a, b), modulus_q);
                o.noinv = 1'b0;
            end
            CMD_INV: begin
                iv = invert(a, modulus_q);
                o.res = iv[7:0];
                o.noinv = iv[8];
            end
            CMD_SBOX: begin
                iv = invert(a, AesPoly);
                o.res = affine(iv[7:0], 1'b1);
                o.noinv = iv[8];
            end
            default: begin
                iv = invert(affine(a, 1'b0), AesPoly);
                o.res = iv[7:0];
                o.noinv = iv[8];
            end
        endcase
        return o;
    endfunction

    // receiver side with random stall
    always @(posedge i_clk) begin
        t_gf_out want;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
            if (o_m_tvalid && i_m_tready) begin
                n_out++;
                if (pending_q.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected result %h/%b", $time, o_m_tdata, o_m_tuser);
                end else begin
                    want = pending_q.pop_front();
                    if (want.res !== o_m_tdata || want.noinv !== o_m_tuser[0]) begin
                        n_err++;
                        $display("%0t: expected %h/%b actual %h/%b", $time,
                                 want.res, want.noinv, o_m_tdata, o_m_tuser);
                    end
                end
            end
        end
    end

    task automatic send(input t_cmd c, input logic [7:0] a, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {b, a};
        i_s_tuser <= c;
        pending_q.push_back(gf_predict(c, a, b));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_modulus(input logic [8:0] m);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        modulus_q = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_rows(input t_row rows[$]);
        t_gf_out got;
        foreach (rows[i]) begin
            if (rows[i].chk) begin
                got = gf_predict(rows[i].cmd, rows[i].a, rows[i].b);
                if (got.res !== rows[i].res || got.noinv !== rows[i].noinv) begin
                    n_err++;
                    $display("%0t: table row %0d expected %h/%b actual %h/%b", $time, i,
                             rows[i].res, rows[i].noinv, got.res, got.noinv);
                end
            end
            send(rows[i].cmd, rows[i].a, rows[i].b);
        end
    endtask

    task automatic random_burst(input int n);
        int   r;
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            c = t_cmd'($urandom_range(3));
            if (r < 5) send(c, 8'hff, 8'hff);
            else if (r < 10) send(c, 8'h00, 8'($urandom));
            else send(c, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        t_row dir[$];
        dir = '{
            '{CMD_MUL, 8'h00, 8'h00, 1, 8'h00, 0},
            '{CMD_MUL, 8'hff, 8'h00, 1, 8'h00, 0},
            '{CMD_MUL, 8'h01, 8'hff, 1, 8'hff, 0},
            '{CMD_MUL, 8'h57, 8'h83, 1, 8'hc1, 0},
            '{CMD_MUL, 8'hff, 8'hff, 0, 8'h00, 0},
            '{CMD_INV, 8'h00, 8'hff, 1, 8'h00, 0},
            '{CMD_INV, 8'h01, 8'h00, 1, 8'h01, 0},
            '{CMD_INV, 8'h53, 8'h00, 1, 8'hca, 0},
            '{CMD_INV, 8'hff, 8'h00, 0, 8'h00, 0},
            '{CMD_SBOX, 8'h00, 8'hff, 1, 8'h63, 0},
            '{CMD_SBOX, 8'h01, 8'h00, 1, 8'h7c, 0},
            '{CMD_SBOX, 8'hff, 8'h00, 1, 8'h16, 0},
            '{CMD_INV_SBOX, 8'h63, 8'h00, 1, 8'h00, 0},
            '{CMD_INV_SBOX, 8'h00, 8'hff, 1, 8'h52, 0},
            '{CMD_INV_SBOX, 8'hff, 8'h00, 1, 8'h7d, 0}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_rows(dir);

        // degenerate moduli: zero truncates, one has no inverses
        set_modulus(9'h000);
        run_rows('{'{CMD_MUL, 8'hff, 8'hff, 1, 8'h55, 0},
                   '{CMD_INV, 8'h02, 8'h00, 0, 8'h00, 0},
                   '{CMD_SBOX, 8'h01, 8'h00, 1, 8'h7c, 0}});
        set_modulus(9'h001);
        run_rows('{'{CMD_MUL, 8'h57, 8'h83, 1, 8'h00, 0},
                   '{CMD_INV, 8'h05, 8'h00, 1, 8'h00, 1},
                   '{CMD_INV, 8'h00, 8'h00, 1, 8'h00, 0}});

        set_modulus(9'h11b); idle_pct = 0;  stall_pct = 0;  random_burst(400);
        set_modulus(9'h1ff); idle_pct = 48; stall_pct = 0;  random_burst(300);
        set_modulus(9'h002); idle_pct = 0;  stall_pct = 48; random_burst(300);
        set_modulus(9'h0a6); idle_pct = 14; stall_pct = 14; random_burst(300);
        drain();
        set_modulus(9'($urandom_range(2, 511))); idle_pct = 0; stall_pct = 0;
        random_burst(300);
        set_modulus(9'h11d); idle_pct = 14; stall_pct = 14; random_burst(300);
        drain();

        $display("Covered all four commands across %0d results and moduli 0x000..0x1ff,",
                 n_out);
        $display("with sender gaps and receiver stalls in separate and mixed phases.");
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
